[rtl/core/fixed_point_alu_macros.svh]
// Assertion macros for the fixed-point ALU top level
`ifndef FIXED_POINT_ALU_MACROS_SVH
`define FIXED_POINT_ALU_MACROS_SVH

// check prop in the same cycle as cond
`define FPA_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// check prop in the cycle after cond
`define FPA_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[rtl/core/fpa_pkg.sv]
// Shared constants, types and saturation helpers for the fixed-point ALU
`timescale 1ns / 1ps

package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 4;
    localparam int QW        = DATA_W + FRAC_BITS;
    localparam int DIV_LAT   = QW + 1;

    localparam logic [DATA_W-1:0]   SMAX      = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0]   SMIN      = 32'h8000_0000;
    localparam logic [2*DATA_W-1:0] POS_LIMIT = 64'h0000_0000_7FFF_FFFF;
    localparam logic [2*DATA_W-1:0] NEG_LIMIT = 64'h0000_0000_8000_0000;
    localparam logic [2*DATA_W-1:0] MUL_HALF  = (64'd1 << FRAC_BITS) >> 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 4'd0,
        CMD_SUB = 4'd1,
        CMD_MUL = 4'd2,
        CMD_DIV = 4'd3,
        CMD_MIN = 4'd4,
        CMD_MAX = 4'd5,
        CMD_INC = 4'd6,
        CMD_DEC = 4'd7,
        CMD_I2F = 4'd8,
        CMD_F2I = 4'd9
    } cmd_t;

    typedef struct packed {
        logic              sat;
        logic [DATA_W-1:0] value;
    } sat_res_t;

    typedef struct packed {
        cmd_t     cmd;
        logic     neg;
        logic     a_neg;
        logic     bzero;
        logic     less;
        logic     equal;
        logic     greater;
        sat_res_t simple;
        sat_res_t mul;
    } side_t;

    // apply sign to a magnitude and clamp to the signed word range
    function automatic sat_res_t saturate(input logic [2*DATA_W-1:0] mag, input logic neg);
        sat_res_t r;
        r.sat   = 1'b0;
        r.value = mag[DATA_W-1:0];
        if (neg)
        begin
            if (mag > NEG_LIMIT)
            begin
                r.sat   = 1'b1;
                r.value = SMIN;
            end
            else
            begin
                r.value = (~mag[DATA_W-1:0]) + 32'd1;
            end
        end
        else if (mag > POS_LIMIT)
        begin
            r.sat   = 1'b1;
            r.value = SMAX;
        end
        return r;
    endfunction

    // clamp a sign-extended sum back to one word
    function automatic sat_res_t clamp33(input logic [DATA_W:0] s);
        sat_res_t r;
        r.sat = s[DATA_W] ^ s[DATA_W-1];
        if (r.sat)
        begin
            r.value = s[DATA_W] ? SMIN : SMAX;
        end
        else
        begin
            r.value = s[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/fixed_point_alu.sv]
// Top level of the pipelined Q24.8 fixed-point ALU
// Input channel s_*: one word per operation, opcode on s_tuser, operands on s_tdata.
// Output channel m_*: one word per accepted input, in order, result and flags on m_tdata.
// The Q24.8 pipeline depth from acceptance to m_tvalid is set by the divider, which
// resolves one quotient bit per pipeline stage and adds a rounding stage; every
// operation travels the same depth so order is kept.
// Throughput is one word per cycle: a new word is taken on every clock while the
// output register is empty or being read.
// When the receiver holds m_tready low with a word waiting, the whole pipeline
// freezes and s_tready drops; nothing is dropped or repeated.
// Reset clears every stage valid bit and the output valid; payload registers are
// left as they are.
// Unused opcodes return zero with only the compare flags set.
// Division by zero clamps by the dividend sign and raises divide_by_zero alone.
`timescale 1ns / 1ps
`include "fixed_point_alu_macros.svh"

module fixed_point_alu
    import fpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // operand_a [31:0], operand_b [63:32]
    input  logic [3:0]  s_tuser,  // cmd [3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // result [31:0], less, equal, greater, saturated,
                                  // divide_by_zero [36], zero [39:37]
);

    logic              pipe_en;

    logic              valid0_reg;
    cmd_t              cmd0_reg;
    logic [DATA_W-1:0] a0_reg;
    logic [DATA_W-1:0] b0_reg;

    logic [DIV_LAT:0]  valid_reg;
    logic [DIV_LAT:0]  valid_next;
    side_t             side_reg  [0:DIV_LAT];
    side_t             side_next [0:DIV_LAT];
    logic [DATA_W-1:0] mag_a_reg;
    logic [DATA_W-1:0] mag_b_reg;

    logic [DATA_W-1:0] mag_a_next;
    logic [DATA_W-1:0] mag_b_next;
    side_t             prep;

    sat_res_t          mul_res;
    logic [QW-1:0]     quo;

    logic              m_valid_reg;
    logic [DATA_W-1:0] res_reg;
    logic              less_reg;
    logic              equal_reg;
    logic              greater_reg;
    logic              sat_reg;
    logic              dz_reg;

    sat_res_t          fin;
    logic              dz_next;
    side_t             last;

    assign pipe_en  = !m_valid_reg || m_tready;
    assign s_tready = pipe_en;

    // capture the word
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            cmd0_reg <= cmd_t'(s_tuser[CMD_W-1:0]);
            a0_reg   <= s_tdata[DATA_W-1:0];
            b0_reg   <= s_tdata[2*DATA_W-1:DATA_W];
        end
    end

    // decode and the simple operations
    always_comb
    begin
        mag_a_next   = a0_reg[DATA_W-1] ? (32'd0 - a0_reg) : a0_reg;
        mag_b_next   = b0_reg[DATA_W-1] ? (32'd0 - b0_reg) : b0_reg;
        prep         = '0;
        prep.cmd     = cmd0_reg;
        prep.a_neg   = a0_reg[DATA_W-1];
        prep.neg     = a0_reg[DATA_W-1] ^ b0_reg[DATA_W-1];
        prep.bzero   = b0_reg == '0;
        prep.less    = $signed(a0_reg) < $signed(b0_reg);
        prep.equal   = a0_reg == b0_reg;
        prep.greater = $signed(a0_reg) > $signed(b0_reg);
        case (cmd0_reg)
            CMD_ADD: prep.simple = clamp33({a0_reg[DATA_W-1], a0_reg}
                                           + {b0_reg[DATA_W-1], b0_reg});
            CMD_SUB: prep.simple = clamp33({a0_reg[DATA_W-1], a0_reg}
                                           - {b0_reg[DATA_W-1], b0_reg});
            CMD_INC: prep.simple = clamp33({a0_reg[DATA_W-1], a0_reg} + 33'd1);
            CMD_DEC: prep.simple = clamp33({a0_reg[DATA_W-1], a0_reg} - 33'd1);
            CMD_MIN: prep.simple.value = prep.less ? a0_reg : b0_reg;
            CMD_MAX: prep.simple.value = prep.greater ? a0_reg : b0_reg;
            CMD_I2F: prep.simple = saturate(64'(mag_a_next) << FRAC_BITS,
                                            a0_reg[DATA_W-1]);
            CMD_F2I: prep.simple.value = $signed(a0_reg) >>> FRAC_BITS;
            default: prep.simple = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            mag_a_reg <= mag_a_next;
            mag_b_reg <= mag_b_next;
        end
    end

    fpa_mul u_mul (
        .clk   (clk),
        .en    (pipe_en),
        .mag_a (mag_a_reg),
        .mag_b (mag_b_reg),
        .neg   (side_reg[0].neg),
        .res   (mul_res)
    );

    fpa_divider u_div (
        .clk (clk),
        .en  (pipe_en),
        .num (QW'(mag_a_reg) << FRAC_BITS),
        .den (mag_b_reg),
        .quo (quo)
    );

    // advance the side line alongside the divider
    always_comb
    begin
        side_next[0] = prep;
        for (int k = 1; k <= DIV_LAT; k++)
        begin
            side_next[k] = side_reg[k-1];
        end
        side_next[2].mul = mul_res;
        valid_next = {valid_reg[DIV_LAT-1:0], valid0_reg};
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int k = 0; k <= DIV_LAT; k++)
            begin
                side_reg[k] <= side_next[k];
            end
        end
    end

    // final selection
    always_comb
    begin
        last    = side_reg[DIV_LAT];
        dz_next = 1'b0;
        case (last.cmd)
            CMD_MUL: fin = last.mul;
            CMD_DIV:
            begin
                if (last.bzero)
                begin
                    dz_next   = 1'b1;
                    fin.sat   = 1'b0;
                    fin.value = last.a_neg ? SMIN : SMAX;
                end
                else
                begin
                    fin = saturate(64'(quo), last.neg);
                end
            end
            default: fin = last.simple;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            res_reg     <= fin.value;
            sat_reg     <= fin.sat;
            dz_reg      <= dz_next;
            less_reg    <= last.less;
            equal_reg   <= last.equal;
            greater_reg <= last.greater;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg  <= 1'b0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            valid0_reg  <= s_tvalid;
            valid_reg   <= valid_next;
            m_valid_reg <= valid_reg[DIV_LAT];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, dz_reg, sat_reg, greater_reg, equal_reg, less_reg, res_reg};

    `FPA_ASSERT_NOW(a_cmp_onehot, m_valid_reg,
        $countones({less_reg, equal_reg, greater_reg}) == 1, "compare flags not exclusive")
    `FPA_ASSERT_NOW(a_dz_clamp, m_valid_reg && dz_reg,
        !sat_reg && (res_reg == SMAX || res_reg == SMIN), "bad divide-by-zero word")
    `FPA_ASSERT_NOW(a_sat_clamp, m_valid_reg && sat_reg,
        res_reg == SMAX || res_reg == SMIN, "saturated word not at a limit")
    `FPA_ASSERT_NEXT(a_stall_hold, !pipe_en,
        $stable({valid0_reg, valid_reg}), "pipeline moved while stalled")

endmodule

[rtl/core/fpa_mul.sv]
// Registered magnitude multiplier with rounding and saturation
`timescale 1ns / 1ps

module fpa_mul
    import fpa_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [DATA_W-1:0] mag_a,
    input  logic [DATA_W-1:0] mag_b,
    input  logic              neg,
    output sat_res_t          res
);

    logic [2*DATA_W-1:0] prod_reg;
    logic [2*DATA_W-1:0] prod_next;
    logic                neg_reg;
    logic [2*DATA_W-1:0] rounded;

    assign prod_next = mag_a * mag_b;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            neg_reg  <= neg;
        end
    end

    assign rounded = (prod_reg + MUL_HALF) >> FRAC_BITS;
    assign res     = saturate(rounded, neg_reg);

endmodule

[rtl/core/fpa_divider.sv]
// Pipelined restoring divider, one quotient bit per stage, rounded half up
`timescale 1ns / 1ps

module fpa_divider
    import fpa_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [QW-1:0]     num,
    input  logic [DATA_W-1:0] den,
    output logic [QW-1:0]     quo
);

    logic [DATA_W-1:0] rem_w [0:QW];
    logic [QW-1:0]     num_w [0:QW];
    logic [DATA_W-1:0] den_w [0:QW];

    logic [DATA_W-1:0] rem_reg [0:QW-1];
    logic [QW-1:0]     num_reg [0:QW-1];
    logic [DATA_W-1:0] den_reg [0:QW-1];

    logic [QW-1:0]     quo_reg;
    logic              round_up;

    assign rem_w[0] = '0;
    assign num_w[0] = num;
    assign den_w[0] = den;

    generate
        for (genvar j = 0; j < QW; j++)
        begin : g_stage
            logic [DATA_W:0]   trial;
            logic [DATA_W:0]   diff;
            logic              ge;
            logic [DATA_W-1:0] rem_next;
            logic [QW-1:0]     num_next;

            assign trial    = {rem_w[j], num_w[j][QW-1]};
            assign diff     = trial - {1'b0, den_w[j]};
            assign ge       = trial >= {1'b0, den_w[j]};
            assign rem_next = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            assign num_next = {num_w[j][QW-2:0], ge};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= rem_next;
                    num_reg[j] <= num_next;
                    den_reg[j] <= den_w[j];
                end
            end

            assign rem_w[j+1] = rem_reg[j];
            assign num_w[j+1] = num_reg[j];
            assign den_w[j+1] = den_reg[j];
        end
    endgenerate

    assign round_up = {rem_w[QW], 1'b0} >= {1'b0, den_w[QW]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= num_w[QW] + QW'(round_up);
        end
    end

    assign quo = quo_reg;

endmodule
